// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the line deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk_i outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hdl/crlf_pkg.sv -----
// Types and constants of the CRLF line deframer.
`timescale 1ns / 1ps
package crlf_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned CNT_W  = 12;
  localparam int unsigned CFG_W  = 12;
  localparam int unsigned IDX_W  = 2;

  localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
  localparam logic [CNT_W-1:0]  RAW_MAX = 12'hFFF;

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_CLOSE = 1'b1;

  localparam logic [LEN_W-1:0] CONTENT_LIMIT_RST = 10'd511;
  localparam logic [CNT_W-1:0] FLOOD_LIMIT_RST   = 12'd612;
  localparam logic [CNT_W-1:0] PENDING_LIMIT_RST = 12'd2048;

  typedef enum logic [IDX_W-1:0] {
    REG_CONTENT_LIMIT = 2'd0,
    REG_FLOOD_LIMIT   = 2'd1,
    REG_PENDING_LIMIT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_CONTENT  = 2'd0,
    KIND_LINE     = 2'd1,
    KIND_FLOOD    = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } result_t;

  // One queue entry: the results caused by one accepted word.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] data;
  } cfg_t;

endpackage

// ----- hdl/crlf_if.sv -----
// Valid/ready channel interfaces for the line deframer input and results.
`timescale 1ns / 1ps
interface crlf_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [crlf_pkg::BYTE_W-1:0] byte_value;

  modport source (output valid, command, byte_value, input ready);
  modport sink   (input valid, command, byte_value, output ready);
endinterface

interface crlf_out_if;
  logic                        valid;
  logic                        ready;
  crlf_pkg::kind_e             kind;
  logic [crlf_pkg::BYTE_W-1:0] out_byte;
  logic [crlf_pkg::LEN_W-1:0]  line_length;
  logic                        last;

  modport source (output valid, kind, out_byte, line_length, last, input ready);
  modport sink   (input valid, kind, out_byte, line_length, last, output ready);
endinterface

// ----- hdl/crlf_line_deframer.sv -----
// Top level of the CRLF line deframer.
//
// Usage: words enter on rx_i (command, byte_value) under valid/ready; results
// leave on tx_o (kind, out_byte, line_length, last), one word per result, with
// last set on the final result that an input word causes. Content bytes pass
// through as they arrive; a CR is held until the next byte shows whether it
// ends the line. Limits are written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user must do so only while the block is idle; the block does not
// enforce it. An index beyond the pending limit is ignored. An accepted word
// goes into the result queue and then into the output register that drives
// tx_o. Throughput: one input word per cycle; the output register issues one
// result per cycle while tx_o.ready allows, so a word that causes two results
// issues them one after another. The front end stalls only when the result
// queue (QUEUE_DEPTH entries) fills: tx_o.ready held low or pairs piling up.
// Reset: limits return to 511, 612 and 2048, the session opens with an empty
// line, and the queue and output register empty. No clearing pass is needed.
// Once the session closes, every word is taken and dropped.
`timescale 1ns / 1ps
module crlf_line_deframer import crlf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  crlf_in_if.sink          rx_i,
  crlf_out_if.source       tx_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  // Configuration write bundle towards the front end.
  cfg_t   cfg;
  // Front to queue.
  logic   push, full;
  entry_t entry;
  // Queue to back end.
  logic   q_valid, pop;
  entry_t head;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  // Classify each word and advance the line state.
  crlf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .rx      (rx_i),
    .push_o  (push),
    .entry_o (entry),
    .full_i  (full)
  );

  // Hold queued results so front and back stall independently.
  crlf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .valid_o (q_valid),
    .head_o  (head),
    .pop_i   (pop)
  );

  // Drop entries onto the output one result at a time.
  crlf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .head_i  (head),
    .pop_o   (pop),
    .tx      (tx_o)
  );

endmodule

// ----- hdl/crlf_front.sv -----
// Front end: takes input words, tracks line state and classifies results.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crlf_front import crlf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  crlf_in_if.sink rx,
  output logic   push_o,
  output entry_t entry_o,
  input  logic   full_i
);

  logic [LEN_W-1:0] content_lim_q;
  logic [CNT_W-1:0] flood_lim_q, pending_lim_q;
  logic             closed_q, closed_d;
  logic [CNT_W-1:0] raw_q, raw_d;
  logic [LEN_W-1:0] emit_q, emit_d;
  logic             cr_q, cr_d;

  logic             accept, work, has;
  logic [CNT_W:0]   raw_inc;
  logic             overflow, is_lf, is_cr, content_nz, flood;
  logic             pass_cr, pass_b;
  logic [LEN_W-1:0] e1, e2;
  entry_t           ent;

  // Closed sessions swallow every word.
  assign rx.ready = closed_q | ~full_i;
  assign accept   = rx.valid & rx.ready;
  assign work     = accept & ~closed_q;

  assign raw_inc    = {1'b0, raw_q} + {{CNT_W{1'b0}}, 1'b1};
  assign overflow   = raw_inc > {1'b0, pending_lim_q};
  assign is_lf      = rx.byte_value == BYTE_LF;
  assign is_cr      = rx.byte_value == BYTE_CR;
  assign content_nz = raw_q != {{(CNT_W-1){1'b0}}, cr_q};
  assign flood      = raw_q > flood_lim_q;
  assign pass_cr    = cr_q & (emit_q < content_lim_q);
  assign e1         = emit_q + {{(LEN_W-1){1'b0}}, pass_cr};
  assign pass_b     = ~is_cr & (e1 < content_lim_q);
  assign e2         = e1 + {{(LEN_W-1){1'b0}}, pass_b};

  always_comb begin
    ent      = '0;
    has      = 1'b0;
    closed_d = closed_q;
    raw_d    = raw_q;
    emit_d   = emit_q;
    cr_d     = cr_q;
    if (rx.command == CMD_CLOSE) begin
      closed_d = 1'b1;
      raw_d    = '0;
      emit_d   = '0;
      cr_d     = 1'b0;
    end else if (overflow) begin
      has         = 1'b1;
      ent.r0.kind = KIND_OVERFLOW;
      closed_d    = 1'b1;
      raw_d       = '0;
      emit_d      = '0;
      cr_d        = 1'b0;
    end else if (is_lf) begin
      if (content_nz) begin
        has = 1'b1;
        if (flood) begin
          ent.r0.kind = KIND_FLOOD;
          closed_d    = 1'b1;
        end else begin
          ent.r0.kind = KIND_LINE;
          ent.r0.len  = emit_q;
        end
      end
      raw_d  = '0;
      emit_d = '0;
      cr_d   = 1'b0;
    end else begin
      raw_d  = (raw_q == RAW_MAX) ? raw_q : raw_inc[CNT_W-1:0];
      cr_d   = is_cr;
      emit_d = e2;
      has    = pass_cr | pass_b;
      if (pass_cr) begin
        ent.r0.data = BYTE_CR;
        if (pass_b) begin
          ent.two     = 1'b1;
          ent.r1.data = rx.byte_value;
        end
      end else if (pass_b) begin
        ent.r0.data = rx.byte_value;
      end
    end
  end

  assign push_o  = work & has;
  assign entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q <= 1'b0;
      raw_q    <= '0;
      emit_q   <= '0;
      cr_q     <= 1'b0;
    end else if (work) begin
      closed_q <= closed_d;
      raw_q    <= raw_d;
      emit_q   <= emit_d;
      cr_q     <= cr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      content_lim_q <= CONTENT_LIMIT_RST;
      flood_lim_q   <= FLOOD_LIMIT_RST;
      pending_lim_q <= PENDING_LIMIT_RST;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        REG_CONTENT_LIMIT: content_lim_q <= cfg_i.data[LEN_W-1:0];
        REG_FLOOD_LIMIT:   flood_lim_q   <= cfg_i.data[CNT_W-1:0];
        REG_PENDING_LIMIT: pending_lim_q <= cfg_i.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  `ASSERT_AT(a_closed_sticky, closed_q |=> closed_q, "session reopened after close")
  `ASSERT_NEVER(a_closed_silent, closed_q && push_o, "result queued on a closed session")
  `ASSERT_NEVER(a_push_full, push_o && full_i, "result queued while queue full")

endmodule

// ----- hdl/crlf_queue.sv -----
// Short queue of result entries between the front and back ends.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crlf_queue import crlf_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  output logic   valid_o,
  output entry_t head_o,
  input  logic   pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NUM_W = $clog2(DEPTH + 1);

  entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NUM_W-1:0] num_q, num_d;

  assign full_o  = num_q == NUM_W'(DEPTH);
  assign valid_o = num_q != '0;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    num_d = num_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      num_d = num_q + 1'b1;
    end else if (pop_i && !push_i) begin
      num_d = num_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      num_q <= num_d;
    end
  end

  `ASSERT_AT(a_num_bound, num_q <= NUM_W'(DEPTH), "queue fill beyond depth")
  `ASSERT_NEVER(a_pop_empty, pop_i && !valid_o, "pop from empty queue")

endmodule

// ----- hdl/crlf_back.sv -----
// Back end: splits queue entries into single results behind an output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crlf_back import crlf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  entry_t    head_i,
  output logic      pop_o,
  crlf_out_if.source tx
);

  logic    out_valid_q;
  logic    half_q, half_d;
  result_t res_q;
  logic    last_q;
  logic    load, last_d;
  result_t res_d;

  assign load   = valid_i & (~out_valid_q | tx.ready);
  assign res_d  = half_q ? head_i.r1 : head_i.r0;
  assign last_d = half_q | ~head_i.two;
  assign pop_o  = load & last_d;
  assign half_d = load ? (~half_q & head_i.two) : half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      half_q      <= 1'b0;
    end else begin
      half_q <= half_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (tx.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= res_d;
      last_q <= last_d;
    end
  end

  assign tx.valid       = out_valid_q;
  assign tx.kind        = res_q.kind;
  assign tx.out_byte    = res_q.data;
  assign tx.line_length = res_q.len;
  assign tx.last        = last_q;

  `ASSERT_AT(a_half_two, half_q |-> (valid_i && head_i.two), "second half without pair entry")

endmodule
